### src/flight_phase_detector_defines.svh
// ----------------------------------------------------------------------------
// Flight phase detector assertion macros
// Concurrent assertion shorthands clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FLIGHT_PHASE_DETECTOR_DEFINES_SVH
`define FLIGHT_PHASE_DETECTOR_DEFINES_SVH

// check an expression at every clock edge
`define FPD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// check that an antecedent implies a consequent in the same cycle
`define FPD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### src/fpd_pkg.sv
// ----------------------------------------------------------------------------
// Flight phase detector package
// Payload types, phase codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package fpd_pkg;

  localparam int unsigned ALT_W   = 24;
  localparam int unsigned THR_W   = 23;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned PHASE_W = 3;

  localparam logic [PHASE_W-1:0] PH_POWERUP   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_READY     = 3'd1;
  localparam logic [PHASE_W-1:0] PH_FLIGHT    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_LANDED    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_SAVE      = 3'd4;
  localparam logic [PHASE_W-1:0] PH_POWERDOWN = 3'd5;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FORCE  = 1'b1;

  localparam logic [1:0] REG_BASE_ALT  = 2'd0;
  localparam logic [1:0] REG_LAUNCH    = 2'd1;
  localparam logic [1:0] REG_LANDED    = 2'd2;
  localparam logic [1:0] REG_WAIT      = 2'd3;

  localparam logic [ALT_W-1:0]  BASE_ALT_RST = 24'sd0;
  localparam logic [THR_W-1:0]  LAUNCH_RST   = 23'd1280;
  localparam logic [THR_W-1:0]  LANDED_RST   = 23'd256;
  localparam logic [TIME_W-1:0] WAIT_RST     = 32'd60000;

  typedef struct packed {
    logic                     op;
    logic signed [ALT_W-1:0]  altitude;
    logic [TIME_W-1:0]        now_ms;
    logic [PHASE_W-1:0]       forced_phase;
  } fpd_in_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               collecting;
  } fpd_out_t;

endpackage

`default_nettype wire

### src/fpd_ram.sv
// ----------------------------------------------------------------------------
// Flight phase detector RAM
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fpd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 30
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/flight_phase_detector.sv
// ----------------------------------------------------------------------------
// Flight phase detector
// Tracks the rocket flight phase from barometric altitude samples.
//
//   channel   direction  handshake                    payload
//   in        input      in_valid_i / in_ready_o      fpd_pkg::fpd_in_t
//   out       output     out_valid_o / out_ready_i    fpd_pkg::fpd_out_t
//   config    input      psel/penable/pwrite, pready  pwdata / prdata
//
// One item per cycle while the result register is free or taken; each item's result
// passes the input register (with the altitude ring read), then the result register.
// The ring lives in a RAM written and read at each sample transfer; a fill count
// stands in for clearing it, so no sweep follows reset.
// Both stages hold while the result register is full and not taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "flight_phase_detector_defines.svh"

module flight_phase_detector #(
  parameter int unsigned WINDOW = 30
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire fpd_pkg::fpd_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output fpd_pkg::fpd_out_t      out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int unsigned AW = $clog2(WINDOW);
  localparam logic [AW-1:0] WR_RST = AW'(1 % WINDOW);
  localparam logic [AW-1:0] RD_RST = AW'(2 % WINDOW);
  localparam logic [AW-1:0] LAST   = AW'(WINDOW - 1);
  localparam int unsigned DW = fpd_pkg::ALT_W + 1;

  // configuration registers
  logic signed [fpd_pkg::ALT_W-1:0] base_q;
  logic [fpd_pkg::THR_W-1:0]        launch_q;
  logic [fpd_pkg::THR_W-1:0]        landed_q;
  logic [fpd_pkg::TIME_W-1:0]       wait_q;
  logic                             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= fpd_pkg::BASE_ALT_RST;
      launch_q <= fpd_pkg::LAUNCH_RST;
      landed_q <= fpd_pkg::LANDED_RST;
      wait_q   <= fpd_pkg::WAIT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        fpd_pkg::REG_BASE_ALT: base_q   <= pwdata[fpd_pkg::ALT_W-1:0];
        fpd_pkg::REG_LAUNCH:   launch_q <= pwdata[fpd_pkg::THR_W-1:0];
        fpd_pkg::REG_LANDED:   landed_q <= pwdata[fpd_pkg::THR_W-1:0];
        fpd_pkg::REG_WAIT:     wait_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      fpd_pkg::REG_BASE_ALT: prdata = {{(32-fpd_pkg::ALT_W){base_q[fpd_pkg::ALT_W-1]}}, base_q};
      fpd_pkg::REG_LAUNCH:   prdata = {{(32-fpd_pkg::THR_W){1'b0}}, launch_q};
      fpd_pkg::REG_LANDED:   prdata = {{(32-fpd_pkg::THR_W){1'b0}}, landed_q};
      fpd_pkg::REG_WAIT:     prdata = wait_q;
      default:               prdata = '0;
    endcase
  end

  // handshake and stage control
  logic              s1_vld_q;
  fpd_pkg::fpd_in_t  s1_q;
  logic              old_vld_q;
  logic              out_vld_q;
  fpd_pkg::fpd_out_t out_q;
  logic              s1_adv;
  logic              in_xfer;
  logic              smp_xfer;

  assign s1_adv     = s1_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !s1_vld_q || s1_adv;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign smp_xfer   = in_xfer && (in_data_i.op == fpd_pkg::OP_SAMPLE);

  // ring pointers and fill count
  logic [AW-1:0] wr_q, wr_d;
  logic [AW-1:0] rd_q, rd_d;
  logic [AW-1:0] fill_q;
  logic          old_vld_d;
  logic [fpd_pkg::ALT_W-1:0] ring_rdata;

  assign wr_d      = (wr_q == LAST) ? '0 : wr_q + 1'b1;
  assign rd_d      = (rd_q == LAST) ? '0 : rd_q + 1'b1;
  assign old_vld_d = (fill_q == LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= WR_RST;
      rd_q   <= RD_RST;
      fill_q <= '0;
    end else if (smp_xfer) begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      if (!old_vld_d) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  fpd_ram #(
    .WIDTH (fpd_pkg::ALT_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (smp_xfer),
    .waddr_i (wr_q),
    .wdata_i (in_data_i.altitude),
    .re_i    (smp_xfer),
    .raddr_i (rd_q),
    .rdata_o (ring_rdata)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q <= in_data_i;
    end
    if (smp_xfer) begin
      old_vld_q <= old_vld_d;
    end
  end

  // phase step
  logic [fpd_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic                        coll_q, coll_d;
  logic [fpd_pkg::TIME_W-1:0]  stamp_q, stamp_d;
  logic signed [DW-1:0]        old_alt;
  logic signed [DW-1:0]        cur_alt;
  logic signed [DW-1:0]        base_ext;
  logic signed [DW-1:0]        base_diff;
  logic signed [DW-1:0]        old_diff;
  logic [DW-1:0]               base_abs;
  logic [DW-1:0]               old_abs;
  logic [fpd_pkg::TIME_W-1:0]  elapsed;

  assign cur_alt   = DW'(s1_q.altitude);
  assign base_ext  = DW'(base_q);
  assign old_alt   = old_vld_q ? DW'($signed(ring_rdata)) : '0;
  assign base_diff = base_ext - cur_alt;
  assign old_diff  = old_alt - cur_alt;
  assign base_abs  = base_diff[DW-1] ? DW'(-base_diff) : DW'(base_diff);
  assign old_abs   = old_diff[DW-1] ? DW'(-old_diff) : DW'(old_diff);
  assign elapsed   = s1_q.now_ms - stamp_q;

  always_comb begin
    phase_d = phase_q;
    coll_d  = coll_q;
    stamp_d = stamp_q;
    if (s1_q.op == fpd_pkg::OP_FORCE) begin
      if (s1_q.forced_phase <= fpd_pkg::PH_POWERDOWN) begin
        phase_d = s1_q.forced_phase;
      end
    end else begin
      unique case (phase_q)
        fpd_pkg::PH_POWERUP: begin
          coll_d = 1'b0;
        end
        fpd_pkg::PH_READY: begin
          coll_d = 1'b1;
          if (base_abs > DW'(launch_q)) begin
            phase_d = fpd_pkg::PH_FLIGHT;
          end
        end
        fpd_pkg::PH_FLIGHT: begin
          if (old_abs < DW'(landed_q)) begin
            phase_d = fpd_pkg::PH_LANDED;
            stamp_d = s1_q.now_ms;
          end
        end
        fpd_pkg::PH_LANDED: begin
          if (elapsed > wait_q) begin
            phase_d = fpd_pkg::PH_SAVE;
            coll_d  = 1'b0;
          end
        end
        fpd_pkg::PH_SAVE: begin
          phase_d = fpd_pkg::PH_POWERDOWN;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= fpd_pkg::PH_POWERUP;
      coll_q  <= 1'b1;
      stamp_q <= '0;
    end else if (s1_adv) begin
      phase_q <= phase_d;
      coll_q  <= coll_d;
      stamp_q <= stamp_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.phase      <= phase_d;
      out_q.collecting <= coll_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // assertions
  `FPD_ASSERT_IMPL(a_ptr_gap, 1'b1, rd_q == wr_d, "ring read pointer not one past write slot")
  `FPD_ASSERT_IMPL(a_fill_max, 1'b1, fill_q <= LAST, "ring fill count overran window")
  `FPD_ASSERT_IMPL(a_coll_fall, $fell(coll_q),
    phase_q == fpd_pkg::PH_POWERUP || phase_q == fpd_pkg::PH_SAVE,
    "collecting dropped outside power-up or save")
  `FPD_ASSERT_IMPL(a_stamp_chg, !$stable(stamp_q), phase_q == fpd_pkg::PH_LANDED,
    "landed stamp changed without entering landed")

endmodule

`default_nettype wire
